>>> src/tep_pkg.sv
`timescale 1ns / 1ps
package tep_pkg;

   localparam int TIME_W  = 48;
   localparam int STAMP_W = 64;
   localparam int TAG_W   = 32;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_POP     = 2'd1;
   localparam logic [1:0] CMD_ADVANCE = 2'd2;

   localparam logic [1:0] STAT_INSERTED = 2'd0;
   localparam logic [1:0] STAT_POPPED   = 2'd1;
   localparam logic [1:0] STAT_NONE     = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0]  due;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT,
      ST_FINAL
   } state_type;

endpackage

>>> src/timed_event_priority_queue.sv
`timescale 1ns / 1ps
// Insert: the slot is written at transfer, then ST_EMIT registers the result.
// Pop: one shared 112-bit compare scans the slot memory, one slot per cycle,
// then ST_DECIDE removes the minimum and ST_EMIT registers the result.
// Advance: a scan and a decide per popped event, one more of each when events stay
// queued, then ST_FINAL registers the final result; a stalled result holds the state.
// One command at a time; reset (synchronous) empties the queue, time and stamp to zero.
module timed_event_priority_queue
   import tep_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [TIME_W-1:0] req_event_time,
   input  logic [TAG_W-1:0]  req_payload_tag,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [TIME_W-1:0] rsp_out_time,
   output logic [TAG_W-1:0]  rsp_out_tag,
   output logic [TIME_W-1:0] rsp_current_time,
   output logic              rsp_last
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type mem [QUEUE_DEPTH];

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [TIME_W-1:0]  now_ff, now_in;

   logic [1:0]        cmd_ff, cmd_in;
   logic [TIME_W-1:0] limit_ff, limit_in;

   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   entry_type        rd_word_ff;

   logic [TIME_W-1:0]  best_time_ff, best_time_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [TAG_W-1:0]   best_tag_ff, best_tag_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   entry_type          last_word_ff, last_word_in;

   logic [1:0]        pend_status_ff, pend_status_in;
   logic [TIME_W-1:0] pend_time_ff, pend_time_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic              popped_ff, popped_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [TIME_W-1:0] rsp_out_time_ff, rsp_out_time_in;
   logic [TAG_W-1:0]  rsp_out_tag_ff, rsp_out_tag_in;
   logic [TIME_W-1:0] rsp_current_time_ff, rsp_current_time_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;

   logic              out_free;
   logic              rd_en;
   logic              take;
   logic              last_cmp;
   logic              due;
   logic              pop_go;
   logic [CNT_W-1:0]  occ_m1;
   logic [TIME_W-1:0] raised_now;
   logic [TIME_W-1:0] ins_time;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_time     = rsp_out_time_ff;
   assign rsp_out_tag      = rsp_out_tag_ff;
   assign rsp_current_time = rsp_current_time_ff;
   assign rsp_last         = rsp_last_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign occ_m1     = occ_ff - 1'b1;
   assign rd_en      = (rd_idx_ff < occ_ff);
   assign last_cmp   = (CNT_W'(cmp_idx_ff) == occ_m1);
   // shared compare unit: earliest time, then smallest stamp
   assign take       = (cmp_idx_ff == '0) ||
                       ({rd_word_ff.due, rd_word_ff.stamp} < {best_time_ff, best_stamp_ff});
   assign due        = (cmd_ff == CMD_POP) || (best_time_ff <= limit_ff);
   assign pop_go     = due && (!popped_ff || out_free);
   assign raised_now = (limit_ff > now_ff) ? limit_ff : now_ff;
   assign ins_time   = (req_event_time < now_ff) ? now_ff : req_event_time;

   always_comb begin
      state_in            = state_ff;
      occ_in              = occ_ff;
      stamp_in            = stamp_ff;
      now_in              = now_ff;
      cmd_in              = cmd_ff;
      limit_in            = limit_ff;
      rd_idx_in           = rd_idx_ff;
      rd_vld_in           = 1'b0;
      cmp_idx_in          = rd_idx_ff[IDX_W-1:0];
      best_time_in        = best_time_ff;
      best_stamp_in       = best_stamp_ff;
      best_tag_in         = best_tag_ff;
      best_idx_in         = best_idx_ff;
      last_word_in        = last_word_ff;
      pend_status_in      = pend_status_ff;
      pend_time_in        = pend_time_ff;
      pend_tag_in         = pend_tag_ff;
      popped_in           = popped_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_status_in       = rsp_status_ff;
      rsp_out_time_in     = rsp_out_time_ff;
      rsp_out_tag_in      = rsp_out_tag_ff;
      rsp_current_time_in = rsp_current_time_ff;
      rsp_last_in         = rsp_last_ff;
      mem_we              = 1'b0;
      mem_waddr           = occ_ff[IDX_W-1:0];
      mem_wdata           = '{due: ins_time, stamp: stamp_ff, tag: req_payload_tag};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_cmd;
               limit_in       = req_event_time;
               popped_in      = 1'b0;
               pend_status_in = STAT_NONE;
               pend_time_in   = '0;
               pend_tag_in    = '0;
               rd_idx_in      = '0;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (occ_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        pend_status_in = STAT_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        stamp_in       = stamp_ff + 1'b1;
                        occ_in         = occ_ff + 1'b1;
                        pend_status_in = STAT_INSERTED;
                     end
                     state_in = ST_EMIT;
                  end
                  CMD_POP: begin
                     state_in = (occ_ff == '0) ? ST_EMIT : ST_SCAN;
                  end
                  CMD_ADVANCE: begin
                     state_in = (occ_ff == '0) ? ST_FINAL : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_vld_in = rd_en;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (take) begin
                  best_time_in  = rd_word_ff.due;
                  best_stamp_in = rd_word_ff.stamp;
                  best_tag_in   = rd_word_ff.tag;
                  best_idx_in   = cmp_idx_ff;
               end
               // the final slot read is the one that fills the hole
               if (last_cmp) begin
                  last_word_in = rd_word_ff;
                  state_in     = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (!due) begin
               state_in = ST_FINAL;
            end else if (pop_go) begin
               if (popped_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_status_in       = pend_status_ff;
                  rsp_out_time_in     = pend_time_ff;
                  rsp_out_tag_in      = pend_tag_ff;
                  rsp_current_time_in = pend_time_ff;
                  rsp_last_in         = 1'b0;
               end
               mem_we         = 1'b1;
               mem_waddr      = best_idx_ff;
               mem_wdata      = last_word_ff;
               occ_in         = occ_m1;
               now_in         = best_time_ff;
               pend_status_in = STAT_POPPED;
               pend_time_in   = best_time_ff;
               pend_tag_in    = best_tag_ff;
               popped_in      = 1'b1;
               rd_idx_in      = '0;
               if (cmd_ff == CMD_POP) begin
                  state_in = ST_EMIT;
               end else if (occ_m1 == '0) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = pend_status_ff;
               rsp_out_time_in     = pend_time_ff;
               rsp_out_tag_in      = pend_tag_ff;
               rsp_current_time_in = now_ff;
               rsp_last_in         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = pend_status_ff;
               rsp_out_time_in     = pend_time_ff;
               rsp_out_tag_in      = pend_tag_ff;
               rsp_current_time_in = raised_now;
               rsp_last_in         = 1'b1;
               now_in              = raised_now;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         now_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         popped_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         now_ff       <= now_in;
         rd_vld_ff    <= rd_vld_in;
         popped_ff    <= popped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff              <= cmd_in;
      limit_ff            <= limit_in;
      rd_idx_ff           <= rd_idx_in;
      cmp_idx_ff          <= cmp_idx_in;
      best_time_ff        <= best_time_in;
      best_stamp_ff       <= best_stamp_in;
      best_tag_ff         <= best_tag_in;
      best_idx_ff         <= best_idx_in;
      last_word_ff        <= last_word_in;
      pend_status_ff      <= pend_status_in;
      pend_time_ff        <= pend_time_in;
      pend_tag_ff         <= pend_tag_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_out_time_ff     <= rsp_out_time_in;
      rsp_out_tag_ff      <= rsp_out_tag_in;
      rsp_current_time_ff <= rsp_current_time_in;
      rsp_last_ff         <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= mem[rd_idx_ff[IDX_W-1:0]];
   end

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && pop_go) |=> occ_ff == $past(occ_ff) - 1'b1)
      else $error("pop did not remove exactly one event");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> now_ff >= $past(now_ff))
      else $error("current time moved backward");
`endif

endmodule

>>> verif/tb_timed_event_priority_queue.sv
`timescale 1ns / 1ps
module tb_timed_event_priority_queue
   import tep_pkg::*;
();

   localparam int unsigned DEPTH        = 64;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam logic [1:0]  CMD_UNDEFINED = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [1:0]        status;
      logic [TIME_W-1:0] out_time;
      logic [TAG_W-1:0]  out_tag;
      logic [TIME_W-1:0] cur_time;
      logic              last;
   } sched_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_cmd;
   logic [TIME_W-1:0] req_event_time;
   logic [TAG_W-1:0]  req_payload_tag;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic [TIME_W-1:0] rsp_out_time;
   logic [TAG_W-1:0]  rsp_out_tag;
   logic [TIME_W-1:0] rsp_current_time;
   logic              rsp_last;

   // scheduler shadow: live events sit unordered in slots 0..sched_count-1
   logic [TIME_W-1:0]  sched_due   [DEPTH];
   logic [STAMP_W-1:0] sched_stamp [DEPTH];
   logic [TAG_W-1:0]   sched_tag   [DEPTH];
   int unsigned        sched_count = 0;
   logic [STAMP_W-1:0] sched_next_stamp = '0;
   logic [TIME_W-1:0]  sched_now = '0;

   sched_result_type expected_results[$];
   int unsigned   error_count = 0;
   int unsigned   sender_idle_pct = 0;
   int unsigned   receiver_stall_pct = 0;
   int unsigned   quiet_cycles = 0;

   timed_event_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_event_time  (req_event_time),
      .req_payload_tag (req_payload_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_time    (rsp_out_time),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_current_time(rsp_current_time),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // append one expected result at the tail
   function automatic void queue_expected(input sched_result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic int unsigned earliest_slot();
      int unsigned best;
      int unsigned i;
      best = 0;
      for (i = 1; i < sched_count; i++) begin
         if (sched_due[i] < sched_due[best] ||
             (sched_due[i] == sched_due[best] && sched_stamp[i] < sched_stamp[best]))
            best = i;
      end
      return best;
   endfunction

   // Remove the earliest event, move time to its due time, return its result.
   function automatic sched_result_type remove_earliest();
      sched_result_type r;
      int unsigned   slot;
      int unsigned   tail;
      slot = earliest_slot();
      tail = sched_count - 1;
      r = '0;
      r.status   = STAT_POPPED;
      r.out_time = sched_due[slot];
      r.out_tag  = sched_tag[slot];
      r.cur_time = sched_due[slot];
      sched_due[slot]   = sched_due[tail];
      sched_stamp[slot] = sched_stamp[tail];
      sched_tag[slot]   = sched_tag[tail];
      sched_count--;
      sched_now = r.out_time;
      return r;
   endfunction

   function automatic void predict_command(input logic [1:0] cmd,
                                           input logic [TIME_W-1:0] t,
                                           input logic [TAG_W-1:0] tag);
      sched_result_type r;
      int unsigned   popped;
      r = '0;
      case (cmd)
         CMD_INSERT: begin
            if (sched_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               sched_due[sched_count]   = (t < sched_now) ? sched_now : t;
               sched_stamp[sched_count] = sched_next_stamp;
               sched_tag[sched_count]   = tag;
               sched_next_stamp++;
               sched_count++;
               r.status = STAT_INSERTED;
            end
            r.cur_time = sched_now;
         end
         CMD_POP: begin
            if (sched_count == 0) begin
               r.status   = STAT_NONE;
               r.cur_time = sched_now;
            end else begin
               r = remove_earliest();
            end
         end
         CMD_ADVANCE: begin
            popped = 0;
            while (sched_count > 0 && sched_due[earliest_slot()] <= t) begin
               if (popped > 0)
                  queue_expected(r);
               r = remove_earliest();
               popped++;
            end
            if (t > sched_now)
               sched_now = t;
            if (popped == 0)
               r.status = STAT_NONE;
            r.cur_time = sched_now;
         end
         default: begin
            r.status   = STAT_NONE;
            r.cur_time = sched_now;
         end
      endcase
      r.last = 1'b1;
      queue_expected(r);
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_result();
      sched_result_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result: status %0d time 0x%0h tag 0x%0h now 0x%0h last %0b",
                  $time, rsp_status, rsp_out_time, rsp_out_tag, rsp_current_time, rsp_last);
         error_count++;
         return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, rsp_status);
      compare_field("out_time", want.out_time, rsp_out_time);
      compare_field("out_tag", want.out_tag, rsp_out_tag);
      compare_field("current_time", want.cur_time, rsp_current_time);
      compare_field("last", want.last, rsp_last);
   endfunction

   // Mostly near the current time; some behind it (raised on insert), a few anywhere.
   function automatic logic [TIME_W-1:0] pick_time(input int unsigned wide_pct,
                                                   input int unsigned spread);
      logic [63:0] wide;
      int unsigned mode;
      wide = {$urandom, $urandom};
      mode = $urandom_range(0, 99);
      if (mode < wide_pct)
         return wide[TIME_W-1:0];
      if (mode < wide_pct + 15)
         return sched_now - TIME_W'($urandom_range(0, 500));
      return sched_now + TIME_W'($urandom_range(0, spread));
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
                            input logic [TAG_W-1:0] tag);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_event_time  <= t;
      req_payload_tag <= tag;
      do @(posedge clock); while (!req_ready);
      predict_command(cmd, t, tag);
   endtask

   task automatic test_empty_and_undefined();
      send_item(CMD_POP, '0, '0);
      send_item(CMD_ADVANCE, '0, '0);
      send_item(CMD_UNDEFINED, TIME_MAX, '1);
      send_item(CMD_POP, '0, '0);
   endtask

   task automatic test_order_and_ties();
      send_item(CMD_INSERT, 48'd30, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 48'd10, 32'h0000_0000);
      send_item(CMD_INSERT, 48'd10, 32'h0000_0001);
      send_item(CMD_POP, '0, '0);
      // behind current time: raised, and queued after the earlier tie
      send_item(CMD_INSERT, 48'd5, 32'h0000_0002);
      send_item(CMD_POP, '0, '0);
      send_item(CMD_ADVANCE, 48'd20, '0);
      send_item(CMD_ADVANCE, 48'd40, '0);
      send_item(CMD_ADVANCE, 48'd40, '0);
      send_item(CMD_INSERT, 48'd45, 32'hA5A5_5A5A);
      send_item(CMD_ADVANCE, 48'd44, '0);
      send_item(CMD_POP, '0, '0);
   endtask

   task automatic test_full_queue();
      int unsigned i;
      sender_idle_pct    = 0;
      receiver_stall_pct = 31;
      for (i = 0; i < DEPTH; i++)
         send_item(CMD_INSERT, pick_time(0, 5000), $urandom);
      send_item(CMD_INSERT, pick_time(0, 5000), $urandom);
      send_item(CMD_INSERT, pick_time(0, 5000), $urandom);
      send_item(CMD_POP, '0, '0);
      send_item(CMD_INSERT, pick_time(0, 5000), $urandom);
      send_item(CMD_INSERT, pick_time(0, 5000), $urandom);
      // drain the whole queue in one advance
      send_item(CMD_ADVANCE, sched_now + TIME_W'(6000), '0);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned i;
      int unsigned roll;
      int unsigned insert_weight;
      logic [1:0]  cmd;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      insert_weight      = 55;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0)
            insert_weight = $urandom_range(35, 75);
         roll = $urandom_range(0, 99);
         if (roll < 3)
            cmd = CMD_UNDEFINED;
         else if (roll < insert_weight)
            cmd = CMD_INSERT;
         else if (roll < insert_weight + (100 - insert_weight) / 2)
            cmd = CMD_POP;
         else
            cmd = CMD_ADVANCE;
         if (cmd == CMD_ADVANCE)
            send_item(cmd, pick_time(2, 3000), $urandom);
         else
            send_item(cmd, pick_time(5, 2000), $urandom);
      end
   endtask

   task automatic test_time_ceiling();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_item(CMD_INSERT, TIME_MAX, $urandom);
      send_item(CMD_INSERT, '0, $urandom);
      send_item(CMD_ADVANCE, TIME_MAX, '0);
      send_item(CMD_INSERT, 48'd1, $urandom);
      send_item(CMD_POP, '0, '0);
      send_item(CMD_ADVANCE, '0, '0);
      send_item(CMD_POP, '0, '0);
   endtask

   // result side: check each transfer, then stall at random
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_result();
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_INSERT;
      req_event_time  <= '0;
      req_payload_tag <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_undefined();
      test_order_and_ties();
      test_full_queue();
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 70, 0);
      test_random_traffic(100, 0, 70);
      test_random_traffic(100, 31, 31);
      test_time_ceiling();

      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
src/tep_pkg.sv
src/timed_event_priority_queue.sv
verif/tb_timed_event_priority_queue.sv
